>>> hw/rtl/sha_pkg.sv
// SHA-256 package: request/response payload types, controller state enum,
// initial hash words, round constants and a rotate-right helper function.
// No dependencies.
package sha_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } sha_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } sha_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_FINISH,
    ST_OUT
  } sha_state_e;

  localparam int unsigned NumRounds = 64;
  localparam logic [7:0]  PadByte   = 8'h80;

  typedef logic [7:0][31:0] sha_hash_t;

  localparam sha_hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hw/rtl/sha256_message_digest.sv
// SHA-256 top level: byte packing, padding sequencer, chain value and
// digest output register. Depends on sha_pkg and sha_round.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid_i/req_stall_o | sha_req_t
//  rsp     | out       | rsp_valid_o/rsp_stall_i | sha_rsp_t
//
// A full word goes through accept, four byte steps, then one step back to idle.
// A word that fills the block also holds the request stalled for the 64
// rounds of the round unit (one round per cycle).
// A last word adds padding: up to 72 byte steps plus one or two
// compressions, then eight digest words, one per cycle unless stalled.
// Reset loads the initial hash words and clears the counts.
module sha256_message_digest (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  sha_pkg::sha_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_stall_i,
  output sha_pkg::sha_rsp_t rsp_o
);
  import sha_pkg::*;

  sha_state_e state_q, state_d;
  sha_hash_t chain_q, chain_d, sum;
  logic [15:0][31:0] buf_q, buf_d;
  logic [5:0] nbytes_q, nbytes_d;
  logic [63:0] bits_q, bits_d;
  logic [31:0] word_q, word_d;
  logic [2:0] cnt_q, cnt_d;       // bytes left in word / pad byte sent flag / out index
  logic last_q, last_d;
  logic [3:0] pad_q, pad_d;       // length bytes pushed, 8 = done
  logic start, done;
  logic [7:0] byte_v;
  logic push, wrap;
  logic busy_q;
  logic req_acc;

  sha_round u_round (
    .clk_i, .rst_ni, .start_i(start), .block_i(buf_d), .chain_i(chain_q),
    .done_o(done), .sum_o(sum)
  );

  // request taken this cycle
  assign req_acc = req_valid_i && !req_stall_o;

  // byte written into buffer at nbytes_q
  always_comb begin
    buf_d = buf_q;
    if (push) buf_d[nbytes_q[5:2]][8'(3 - nbytes_q[1:0]) * 8 +: 8] = byte_v;
  end
  assign wrap = push && (nbytes_q == 6'd63);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_acc) state_d = ST_COMP;
      ST_COMP:
        if (!wrap && cnt_q == 3'd0) begin
          if (pad_q == 4'd0 && !last_q) state_d = ST_IDLE;
          else state_d = last_q ? ST_PAD : ST_IDLE;
        end
      ST_PAD:    if (pad_q == 4'd8 && nbytes_q == 6'd0) state_d = ST_FINISH;
      ST_FINISH: if (done) state_d = ST_OUT;
      ST_OUT:    if (!rsp_stall_i && cnt_q == 3'd7) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
    if (wrap) state_d = (state_q == ST_PAD && pad_q == 4'd7) ? ST_FINISH : state_q;
  end

  // datapath control; round unit stalls everything while busy
  always_comb begin
    chain_d = chain_q; nbytes_d = nbytes_q; bits_d = bits_q; word_d = word_q;
    cnt_d = cnt_q; last_d = last_q; pad_d = pad_q;
    push = 1'b0; byte_v = word_q[31:24];
    if (done) chain_d = sum;
    case (state_q)
      ST_IDLE: if (req_acc) begin
        word_d = req_i.data_word;
        last_d = req_i.end_of_message;
        cnt_d = (req_i.end_of_message && req_i.valid_bytes < 3'd4) ?
                req_i.valid_bytes : 3'd4;
        pad_d = '0;
      end
      ST_COMP: if (!busy_q && cnt_q != 3'd0) begin
        push = 1'b1; byte_v = word_q[31:24];
        word_d = word_q << 8; cnt_d = cnt_q - 3'd1;
        nbytes_d = nbytes_q + 6'd1; bits_d = bits_q + 64'd8;
      end
      ST_PAD: if (!busy_q && !(pad_q == 4'd8 && nbytes_q == 6'd0)) begin
        push = 1'b1;
        nbytes_d = nbytes_q + 6'd1;
        if (cnt_q == 3'd0) begin
          byte_v = PadByte; cnt_d = 3'd1;
        end else if (nbytes_q >= 6'd56 && (pad_q != 4'd0 ||
                     nbytes_q != 6'd56 ? 1'b1 : 1'b0) && pad_q == 4'd0 &&
                     nbytes_q != 6'd56) begin
          byte_v = 8'h00;
        end else if (nbytes_q < 6'd56) begin
          byte_v = 8'h00;
        end else begin
          byte_v = bits_q[8'(7 - pad_q[2:0]) * 8 +: 8];
          pad_d = pad_q + 4'd1;
        end
      end
      ST_OUT: if (!rsp_stall_i) begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          chain_d = InitHash; nbytes_d = '0; bits_d = '0; cnt_d = '0;
        end
      end
      default: ;
    endcase
    if (state_q == ST_COMP && state_d == ST_PAD) cnt_d = '0;
    if (state_q == ST_FINISH && done) cnt_d = '0;
  end
  assign start = wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; chain_q <= InitHash; nbytes_q <= '0; bits_q <= '0;
      cnt_q <= '0; last_q <= 1'b0; pad_q <= '0; busy_q <= 1'b0;
    end else begin
      state_q <= state_d; chain_q <= chain_d; nbytes_q <= nbytes_d;
      bits_q <= bits_d; cnt_q <= cnt_d; last_q <= last_d; pad_q <= pad_d;
      busy_q <= start ? 1'b1 : (done ? 1'b0 : busy_q);
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    word_q <= word_d;
  end

  assign req_stall_o = (state_q != ST_IDLE) || busy_q;
  assign rsp_valid_o = (state_q == ST_OUT);
  assign rsp_o.digest_word = chain_q[cnt_q];
  assign rsp_o.word_number = cnt_q;
  assign rsp_o.final_word = (cnt_q == 3'd7);
endmodule

>>> hw/rtl/sha_round.sv
// SHA-256 round unit: one compression round per cycle with a rolling
// 16-word message schedule. Restarts from the chain value on start.
// Depends on sha_pkg.
module sha_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [15:0][31:0] block_i,
  input  sha_pkg::sha_hash_t chain_i,
  output logic              done_o,
  output sha_pkg::sha_hash_t sum_o
);
  import sha_pkg::*;

  logic [15:0][31:0] w_q, w_d;
  sha_hash_t v_q, v_d;
  logic [5:0] rnd_q, rnd_d;
  logic busy_q, busy_d;
  logic [31:0] w_new, s0, s1, t1, t2, ch, maj;

  // next schedule word and round datapath
  always_comb begin
    s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    ch = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
    maj = (v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1]));
    t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25)) + ch
         + RoundK[rnd_q] + w_q[0];
    t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22)) + maj;
  end

  always_comb begin
    w_d = w_q;
    v_d = v_q;
    rnd_d = rnd_q;
    busy_d = busy_q;
    if (start_i) begin
      w_d = block_i;
      v_d = chain_i;
      rnd_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      w_d = {w_new, w_q[15:1]};
      v_d = {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
      rnd_d = rnd_q + 6'd1;
      if (rnd_q == 6'(NumRounds - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q <= '0;
    end else begin
      busy_q <= busy_d;
      rnd_q <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    v_q <= v_d;
  end

  assign done_o = busy_q && !busy_d;
  always_comb begin
    for (int i = 0; i < 8; i++) sum_o[i] = chain_i[i] + v_d[i];
  end
endmodule

>>> hw/rtl/sha_checker.sv
// Port-level checks for sha256_message_digest, bound to the top level.
// Depends on sha_pkg.
module sha_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_stall_o,
  input sha_pkg::sha_req_t req_i,
  input logic              rsp_valid_o,
  input logic              rsp_stall_i,
  input sha_pkg::sha_rsp_t rsp_o
);
  import sha_pkg::*;

  // no request is taken while a digest is being delivered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o) else $error("request taken during output");

  // final flag only on word seven
  a_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.final_word == (rsp_o.word_number == 3'd7)))
    else $error("final flag mismatch");

  // words advance by one after each taken response but the final one
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_stall_i && !rsp_o.final_word) |=>
    (rsp_valid_o && rsp_o.word_number == $past(rsp_o.word_number) + 3'd1))
    else $error("digest word order");

  // stalled response holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_stall_i) |=> (rsp_valid_o && $stable(rsp_o)))
    else $error("stalled response changed");
endmodule

bind sha256_message_digest sha_checker u_sha_checker (.*);
